// ===== rtl/sha256_message_digest_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the SHA-256 digest block
// Clocked on clock, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef SHA256_MESSAGE_DIGEST_ASSERT_SVH
`define SHA256_MESSAGE_DIGEST_ASSERT_SVH

// same-cycle implication
`define SHA_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sha256 assertion failed");

// next-cycle implication
`define SHA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sha256 assertion failed");

`endif

// ===== rtl/sha256_pkg.sv =====
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types and constants of the SHA-256 digest block.
// ----------------------------------------------------------------------------
package sha256_pkg;

   localparam int QUEUE_DEPTH_DEF = 4;

   typedef struct packed {
      logic       final_byte;
      logic [7:0] msg_byte;
   } queue_item_type;

   typedef enum logic [2:0] {
      ST_FILL,
      ST_PAD80,
      ST_PADZ,
      ST_LEN,
      ST_COMP,
      ST_ADD,
      ST_OUT
   } core_state_type;

   localparam logic [7:0] PAD_MARK = 8'h80;

   localparam logic [31:0] INITIAL_H [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

endpackage

// ===== rtl/sha256_front.sv =====
// ----------------------------------------------------------------------------
// sha256_front
// Input queue: takes message bytes and holds them for the compression core.
// ----------------------------------------------------------------------------
module sha256_front import sha256_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF  // power of two, at least 2
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_push,
   output logic           req_full,
   input  logic [7:0]     req_msg_byte,
   input  logic           req_final_byte,
   output logic           q_valid,
   output queue_item_type q_item,
   input  logic           q_pop
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   queue_item_type     slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign req_full = (count_ff == FULL_CNT);
   assign q_valid  = (count_ff != '0);
   assign q_item   = slot_ff[rd_ptr_ff];
   assign do_push  = req_push && !req_full;
   assign do_pop   = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= '{final_byte: req_final_byte, msg_byte: req_msg_byte};
      end
   end

endmodule

// ===== rtl/sha256_core.sv =====
// ----------------------------------------------------------------------------
// sha256_core
// Block assembly, padding, one-round-per-cycle compression and digest output.
// ----------------------------------------------------------------------------
module sha256_core import sha256_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           q_valid,
   input  queue_item_type q_item,
   output logic           q_pop,
   output logic           rsp_empty,
   input  logic           rsp_pop,
   output logic [31:0]    rsp_digest_word,
   output logic [2:0]     rsp_word_index,
   output logic           rsp_last_word
);

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   core_state_type state_ff, state_in;
   core_state_type ret_ff, ret_in;
   logic [511:0]   blk_ff, blk_in;      // byte shift line, doubles as message schedule
   logic [5:0]     fill_ff, fill_in;
   logic [63:0]    bits_ff, bits_in;
   logic [63:0]    len_ff, len_in;
   logic [5:0]     round_ff, round_in;
   logic [2:0]     idx_ff, idx_in;
   logic [31:0]    v_ff [8];
   logic [31:0]    v_in [8];
   logic [31:0]    chain_ff [8];
   logic [31:0]    chain_in [8];

   logic           shift_en;
   logic [7:0]     shift_byte;
   logic           go_comp;
   logic [31:0]    w0, w1, w9, w14, w_new;
   logic [31:0]    s0, s1, sum0, sum1, ch, maj, t1, t2;

   assign w0  = blk_ff[511:480];
   assign w1  = blk_ff[479:448];
   assign w9  = blk_ff[223:192];
   assign w14 = blk_ff[63:32];

   always_comb begin
      s0    = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
      s1    = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
      w_new = s1 + w9 + s0 + w0;
      sum1  = rotr(v_ff[4], 6) ^ rotr(v_ff[4], 11) ^ rotr(v_ff[4], 25);
      ch    = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      t1    = v_ff[7] + sum1 + ch + ROUND_K[round_ff] + w0;
      sum0  = rotr(v_ff[0], 2) ^ rotr(v_ff[0], 13) ^ rotr(v_ff[0], 22);
      maj   = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t2    = sum0 + maj;
   end

   always_comb begin
      state_in   = state_ff;
      ret_in     = ret_ff;
      blk_in     = blk_ff;
      fill_in    = fill_ff;
      bits_in    = bits_ff;
      len_in     = len_ff;
      round_in   = round_ff;
      idx_in     = idx_ff;
      v_in       = v_ff;
      chain_in   = chain_ff;
      q_pop      = 1'b0;
      shift_en   = 1'b0;
      shift_byte = '0;
      go_comp    = 1'b0;

      case (state_ff)
         ST_FILL: begin
            if (q_valid) begin
               q_pop      = 1'b1;
               shift_en   = 1'b1;
               shift_byte = q_item.msg_byte;
               bits_in    = bits_ff + 64'd8;
               if (q_item.final_byte) begin
                  len_in  = bits_ff + 64'd8;
                  bits_in = '0;
               end
               if (fill_ff == 6'd63) begin
                  go_comp = 1'b1;
                  ret_in  = q_item.final_byte ? ST_PAD80 : ST_FILL;
               end else if (q_item.final_byte) begin
                  state_in = ST_PAD80;
               end
            end
         end
         ST_PAD80: begin
            shift_en   = 1'b1;
            shift_byte = PAD_MARK;
            ret_in     = ST_PADZ;
            state_in   = ST_PADZ;
            go_comp    = (fill_ff == 6'd63);
         end
         ST_PADZ: begin
            if (fill_ff == 6'd56) begin
               state_in = ST_LEN;
            end else begin
               shift_en = 1'b1;
               ret_in   = ST_PADZ;
               go_comp  = (fill_ff == 6'd63);
            end
         end
         ST_LEN: begin
            shift_en   = 1'b1;
            shift_byte = len_ff[63:56];
            len_in     = {len_ff[55:0], 8'h00};
            ret_in     = ST_OUT;
            go_comp    = (fill_ff == 6'd63);
         end
         ST_COMP: begin
            blk_in   = {blk_ff[479:0], w_new};
            round_in = round_ff + 1'b1;
            for (int i = 7; i > 0; i--) begin
               v_in[i] = v_ff[i-1];
            end
            v_in[4] = v_ff[3] + t1;
            v_in[0] = t1 + t2;
            if (round_ff == 6'd63) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            for (int i = 0; i < 8; i++) begin
               chain_in[i] = chain_ff[i] + v_ff[i];
            end
            state_in = ret_ff;
         end
         ST_OUT: begin
            if (rsp_pop) begin
               idx_in = idx_ff + 1'b1;
               if (idx_ff == 3'd7) begin
                  chain_in = INITIAL_H;
                  state_in = ST_FILL;
               end
            end
         end
         default: begin
            state_in = ST_FILL;
         end
      endcase

      if (shift_en) begin
         blk_in  = {blk_ff[503:0], shift_byte};
         fill_in = fill_ff + 1'b1;
      end
      if (go_comp) begin
         state_in = ST_COMP;
         round_in = '0;
         v_in     = chain_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FILL;
         ret_ff   <= ST_FILL;
         fill_ff  <= '0;
         bits_ff  <= '0;
         round_ff <= '0;
         idx_ff   <= '0;
         chain_ff <= INITIAL_H;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         fill_ff  <= fill_in;
         bits_ff  <= bits_in;
         round_ff <= round_in;
         idx_ff   <= idx_in;
         chain_ff <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
      len_ff <= len_in;
      v_ff   <= v_in;
   end

   assign rsp_empty       = (state_ff != ST_OUT);
   assign rsp_digest_word = chain_ff[idx_ff];
   assign rsp_word_index  = idx_ff;
   assign rsp_last_word   = (idx_ff == 3'd7);

endmodule

// ===== rtl/sha256_message_digest.sv =====
// ----------------------------------------------------------------------------
// sha256_message_digest
// SHA-256 over a byte stream, digest returned as eight 32-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   Request side is a queue: drive req_msg_byte/req_final_byte with req_push;
//   a transfer happens when req_push is high and req_full is low. Mark the
//   last byte of each message with req_final_byte.
//   Response side is a queue: while rsp_empty is low the current digest word
//   is shown; rsp_pop takes it. Eight words come per message, word 0 first,
//   rsp_last_word high on word 7.
//   Throughput: one byte per cycle into the block shift line while the core
//   is filling a block; each full 64-byte block then holds the input for the
//   round loop (one round per cycle, then the chaining add).
//   After the final byte transfer, padding shifts one byte a cycle up to the
//   64-byte boundary, then one or two compressions run before the first
//   digest word is shown.
//   A small input queue keeps taking bytes while the core compresses or waits
//   on the response side. A stalled receiver holds the core in its output
//   state; input stalls once the queue fills.
//   Reset (synchronous) loads the initial hash values and empties both sides.
// ----------------------------------------------------------------------------
module sha256_message_digest import sha256_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_msg_byte,
   input  logic        req_final_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   logic           q_valid;
   logic           q_pop;
   queue_item_type q_item;

   sha256_front #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_msg_byte   (req_msg_byte),
      .req_final_byte (req_final_byte),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop)
   );

   sha256_core u_core (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last_word   (rsp_last_word)
   );

endmodule

// ===== rtl/sha256_checker.sv =====
// ----------------------------------------------------------------------------
// sha256_checker
// Port-level checks of the digest output sequence, bound to the top level.
// ----------------------------------------------------------------------------
`include "sha256_message_digest_assert.svh"

module sha256_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [31:0] rsp_digest_word,
   input logic [2:0]  rsp_word_index,
   input logic        rsp_last_word
);

   // a waiting word holds until popped
   `SHA_ASSERT_NEXT(a_hold, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_digest_word) && $stable(rsp_word_index))

   `SHA_ASSERT_IMPL(a_last, !rsp_empty, rsp_last_word == (rsp_word_index == 3'd7))

   // words of one digest come back to back in index order
   `SHA_ASSERT_NEXT(a_seq, !rsp_empty && rsp_pop && !rsp_last_word, !rsp_empty && (rsp_word_index == $past(rsp_word_index) + 3'd1))

   // the next digest needs at least one compression
   `SHA_ASSERT_NEXT(a_gap, !rsp_empty && rsp_pop && rsp_last_word, rsp_empty)

endmodule

bind sha256_message_digest sha256_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_empty       (rsp_empty),
   .rsp_pop         (rsp_pop),
   .rsp_digest_word (rsp_digest_word),
   .rsp_word_index  (rsp_word_index),
   .rsp_last_word   (rsp_last_word)
);
